@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define PPN_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PPN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PPN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ppn_pkg.sv @@
// ---------------------------------------------------------------------------
// ppn_pkg
// Types and constants of the pixel probability normalizer.
// ---------------------------------------------------------------------------
package ppn_pkg;

	localparam int PLANES    = 3;
	localparam int PROB_BITS = 16;
	localparam int Q_BITS    = 16;                          // Q1.15 result width
	localparam int SUM_W     = PROB_BITS + $clog2(PLANES);  // exact sum width
	localparam int REM_W     = SUM_W + 1;                   // partial remainder < 2*sum
	localparam int DIV_CELLS = Q_BITS;                      // one quotient bit per cell

	localparam logic [Q_BITS-1:0] ONE_Q15     = Q_BITS'(32768);
	localparam logic [Q_BITS-1:0] UNIFORM_Q15 = Q_BITS'(32768 / PLANES);

	typedef struct packed {
		logic [PROB_BITS-1:0] prob_2;
		logic [PROB_BITS-1:0] prob_1;
		logic [PROB_BITS-1:0] prob_0;
	} ppn_in_t;

	typedef struct packed {
		logic [Q_BITS-1:0] norm_0;
		logic [Q_BITS-1:0] norm_1;
		logic [Q_BITS-1:0] norm_2;
		logic              uniform_fallback;
	} ppn_out_t;

	// State handed from cell to cell.
	typedef struct packed {
		logic [SUM_W-1:0]                  sum;
		logic                              zero;
		logic [PLANES-1:0][REM_W-1:0]      rem;
		logic [PLANES-1:0][Q_BITS-1:0]     quo;
	} ppn_stage_t;

endpackage

@@ hw/rtl/ppn_sum_cell.sv @@
// ---------------------------------------------------------------------------
// ppn_sum_cell
// Head cell: sums the likelihoods and seeds the division chain.
// ---------------------------------------------------------------------------
module ppn_sum_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  ppn_pkg::ppn_in_t  up_data,
	output logic              up_stall,
	output logic              dn_valid,
	output ppn_pkg::ppn_stage_t dn_data,
	input  logic              dn_stall
);
	import ppn_pkg::*;

	logic [PLANES-1:0][PROB_BITS-1:0] prob;
	logic [SUM_W-1:0]                 sum;
	ppn_stage_t                       nxt;
	logic                             valid_q;
	ppn_stage_t                       data_q;

	assign prob = {up_data.prob_2, up_data.prob_1, up_data.prob_0};

	always_comb begin
		sum = '0;
		for (int p = 0; p < PLANES; p++) begin
			sum = sum + SUM_W'(prob[p]);
		end
		nxt.sum  = sum;
		nxt.zero = (sum == '0);
		for (int p = 0; p < PLANES; p++) begin
			nxt.rem[p] = REM_W'(prob[p]);
			nxt.quo[p] = '0;
		end
	end

	assign up_stall = valid_q && dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;
endmodule

@@ hw/rtl/ppn_div_cell.sv @@
// ---------------------------------------------------------------------------
// ppn_div_cell
// One restoring-division step: one quotient bit for every plane.
// ---------------------------------------------------------------------------
module ppn_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	input  ppn_pkg::ppn_stage_t up_data,
	output logic                up_stall,
	output logic                dn_valid,
	output ppn_pkg::ppn_stage_t dn_data,
	input  logic                dn_stall
);
	import ppn_pkg::*;

	ppn_stage_t       nxt;
	logic [REM_W-1:0] sum_ext;
	logic [REM_W-1:0] diff;
	logic [REM_W-1:0] kept;
	logic             ge;
	logic             valid_q;
	ppn_stage_t       data_q;

	// Remainder enters below 2*sum, leaves below sum, then doubles.
	always_comb begin
		nxt      = up_data;
		sum_ext  = REM_W'(up_data.sum);
		diff     = '0;
		kept     = '0;
		ge       = 1'b0;
		for (int p = 0; p < PLANES; p++) begin
			ge         = (up_data.rem[p] >= sum_ext);
			diff       = up_data.rem[p] - sum_ext;
			kept       = ge ? diff : up_data.rem[p];
			nxt.rem[p] = {kept[REM_W-2:0], 1'b0};
			nxt.quo[p] = {up_data.quo[p][Q_BITS-2:0], ge};
		end
	end

	assign up_stall = valid_q && dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;
endmodule

@@ hw/rtl/pixel_probability_normalizer.sv @@
// ---------------------------------------------------------------------------
// pixel_probability_normalizer
// Per-pixel normalization of class likelihoods to Q1.15 probabilities.
// ---------------------------------------------------------------------------
// While res_stall is low, one pixel transaction is accepted per clock
// and one result transaction leaves per clock once the pipe is full.
// The pixel passes through 17 registers: one cell adds the three
// likelihoods, then a chain of 16 division cells each resolves one
// quotient bit (bit 15 first) for all planes at once. Each cell holds
// its own valid bit, so bubbles collapse and new pixels keep entering
// while a finished result waits on res_stall, until no bubble is left.
// A zero sum gives floor(32768/PLANES) on every plane with uniform_fallback
// set. Outputs are floor(prob * 32768 / sum), never above 32768.
module pixel_probability_normalizer (
	input  logic              clk,
	input  logic              arst_n,
	// pixel transaction
	input  logic              pix_valid,
	input  ppn_pkg::ppn_in_t  pix,
	output logic              pix_stall,
	// result transaction
	output logic              res_valid,
	output ppn_pkg::ppn_out_t res,
	input  logic              res_stall
);
	import ppn_pkg::*;

`include "assert_macros.svh"

	// Chain links: link 0 leaves the sum cell, link DIV_CELLS is the output.
	logic       link_valid [0:DIV_CELLS];
	logic       link_stall [0:DIV_CELLS];
	ppn_stage_t link_data  [0:DIV_CELLS];

	ppn_sum_cell u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_data  (pix),
		.up_stall (pix_stall),
		.dn_valid (link_valid[0]),
		.dn_data  (link_data[0]),
		.dn_stall (link_stall[0])
	);

	for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
		ppn_div_cell u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[k]),
			.up_data  (link_data[k]),
			.up_stall (link_stall[k]),
			.dn_valid (link_valid[k+1]),
			.dn_data  (link_data[k+1]),
			.dn_stall (link_stall[k+1])
		);
	end

	assign link_stall[DIV_CELLS] = res_stall;

	// Last cell's register is the output register; zero-sum override here.
	ppn_stage_t fin;
	assign fin       = link_data[DIV_CELLS];
	assign res_valid = link_valid[DIV_CELLS];

	always_comb begin
		res.norm_0           = fin.zero ? UNIFORM_Q15 : fin.quo[0];
		res.norm_1           = fin.zero ? UNIFORM_Q15 : fin.quo[1];
		res.norm_2           = fin.zero ? UNIFORM_Q15 : fin.quo[2];
		res.uniform_fallback = fin.zero;
	end

	// Checks
	`PPN_ASSERT_IMPL(a_fallback_uniform, res_valid && res.uniform_fallback, res.norm_0 == UNIFORM_Q15 && res.norm_2 == UNIFORM_Q15, "fallback result is not uniform")
	`PPN_ASSERT_IMPL(a_norm_bounded, res_valid && !res.uniform_fallback, res.norm_0 <= ONE_Q15 && res.norm_1 <= ONE_Q15 && res.norm_2 <= ONE_Q15, "normalized value above one")
	`PPN_ASSERT_NEXT(a_accept_loads, pix_valid && !pix_stall, link_valid[0], "accepted pixel lost at sum cell")
	`PPN_ASSERT_IMPL(a_rem_below_sum, link_valid[DIV_CELLS] && !fin.zero, fin.rem[0] < {fin.sum, 1'b0}, "division remainder out of range")

endmodule
